// ===== design/cfr_pkg.sv =====
package cfr_pkg;

  localparam int FrameLength = 8;
  localparam int NumStored   = FrameLength - 2;
  localparam int PosW        = $clog2(FrameLength);
  localparam logic [PosW-1:0] FirstPos = '0;
  localparam logic [PosW-1:0] LastPos  = PosW'(FrameLength - 1);

  typedef enum logic [0:0] {
    FUNC_DATA = 1'b0,
    FUNC_POLL = 1'b1
  } func_e;

  // one input word as it sits in the input register
  typedef struct packed {
    func_e      func;
    logic       link_up;
    logic [7:0] data_byte;
  } in_word_t;

  // one decoded command, packed in tdata order (lowest field last here)
  typedef struct packed {
    logic [31:0] timer_value;
    logic [7:0]  output_select;
    logic [7:0]  command_code;
  } result_t;

endpackage

// ===== design/cfr_in_stage.sv =====
module cfr_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  cfr_pkg::in_word_t word_i,
  input  logic              take_i,
  output logic              valid_o,
  output cfr_pkg::in_word_t word_o
);
  import cfr_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== design/cfr_frame_core.sv =====
module cfr_frame_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  cfr_pkg::in_word_t word_i,
  output logic              hit_o,
  output cfr_pkg::result_t  result_o
);
  import cfr_pkg::*;

  logic            rcv_q, rcv_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      frame_q [NumStored];
  logic            is_data;
  logic            store;

  assign is_data = (word_i.func == FUNC_DATA);
  // bytes 1..6 are kept for the result
  assign store = advance_i && is_data && rcv_q && (pos_q != FirstPos) && (pos_q != LastPos);

  always_comb begin
    rcv_d = rcv_q;
    pos_d = pos_q;
    sum_d = sum_q;
    hit_o = 1'b0;
    if (advance_i) begin
      if (!is_data) begin
        if (word_i.link_up) begin
          rcv_d = 1'b1;
        end else if (rcv_q) begin
          rcv_d = 1'b0;
          pos_d = '0;
          sum_d = '0;
        end
      end else if (rcv_q) begin
        if (pos_q != LastPos) begin
          sum_d = sum_q + word_i.data_byte;
          pos_d = pos_q + PosW'(1);
        end else begin
          hit_o = (~sum_q == word_i.data_byte);
          pos_d = '0;
          sum_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q <= 1'b0;
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      rcv_q <= rcv_d;
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      frame_q[pos_q - PosW'(1)] <= word_i.data_byte;
    end
  end

  assign result_o.command_code  = frame_q[0];
  assign result_o.output_select = frame_q[1];
  assign result_o.timer_value   = {frame_q[2], frame_q[3], frame_q[4], frame_q[5]};

endmodule

// ===== design/command_frame_receiver.sv =====
// Command frame receiver.
// Slave channel (s_axis): one word per received link byte or link status poll.
//   tuser selects the kind: 0 = data byte, 1 = status poll. tdata carries the
//   byte and the link-up flag (used by polls only).
// Master channel (m_axis): one word per good 8-byte frame, holding the command
//   byte, the output selector and the big-endian 32-bit timer value.
// Bytes are taken only after a poll has reported the link up; a link-down poll
// drops any partial frame. Bytes 0..6 are summed modulo 256 and byte 7 must be
// the ones' complement of that sum, otherwise the frame is dropped silently.
// Path: the last frame byte is captured in the input register, and the
// checksum/state logic then loads the result register from it once that
// register is free or draining.
// Throughput: one word per cycle while the result register is free or
// draining; the position, sum and byte store update together per word.
// Reset clears the link state, position, sum and both valid flags; the stored
// frame bytes are not reset. When m_axis stalls, the result register holds;
// the input register then fills and s_axis_tready drops until the result
// is taken.
module command_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [8] link_up, [15:9] zero
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [7:0] command_code, [15:8] output_select,
                                      // [47:16] timer_value
);
  import cfr_pkg::*;

  in_word_t in_word;
  in_word_t stage_word;
  logic     stage_valid;
  logic     take;
  logic     hit;
  result_t  result;
  logic     out_valid_q, out_valid_d;
  result_t  out_data_q;

  assign in_word.func      = func_e'(s_axis_tuser);
  assign in_word.link_up   = s_axis_tdata[8];
  assign in_word.data_byte = s_axis_tdata[7:0];

  // the core may consume a word whenever the result register is free or draining
  assign take = stage_valid && (!out_valid_q || m_axis_tready);

  cfr_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .word_i  (in_word),
    .take_i  (take),
    .valid_o (stage_valid),
    .word_o  (stage_word)
  );

  cfr_frame_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (take),
    .word_i    (stage_word),
    .hit_o     (hit),
    .result_o  (result)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (take && hit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && hit) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/cfr_checker.sv =====
module cfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  import cfr_pkg::*;

  logic data_in;
  assign data_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_DATA);

  // reset empties the result register at once
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a fresh result follows an accepted data word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(data_in, 2))
    else $error("result without a preceding data word");

  // with the result register free the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && $past(!m_axis_tvalid) |-> s_axis_tready)
    else $error("input stalled while result register free");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (.*);

// ===== tb/command_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

// Tracks the link state, frame position and checksum of the receiver and
// holds the decoded commands still owed by the block.
class frame_decode_tracker;
  bit                linked   = 1'b0;
  logic [2:0]        position = '0;
  logic [7:0]        checksum = '0;
  logic [7:0]        payload [6];   // frame bytes 1..6
  cfr_pkg::result_t  expected_commands [$];
  int                mismatches    = 0;
  int                commands_seen = 0;

  // Returns 1 when the word is taken by the receiver (not dropped while idle).
  function bit note_word(cfr_pkg::func_e kind, logic [7:0] data, logic link);
    cfr_pkg::result_t cmd;
    if (kind == cfr_pkg::FUNC_POLL) begin
      if (link && !linked) begin
        linked = 1'b1;
      end else if (!link && linked) begin
        linked   = 1'b0;
        position = cfr_pkg::FirstPos;
        checksum = '0;
      end
      return 1'b1;
    end
    if (!linked) return 1'b0;
    if (position != cfr_pkg::LastPos) begin
      if (position != cfr_pkg::FirstPos) payload[position - 1] = data;
      checksum = checksum + data;
      position = position + 1'b1;
      return 1'b1;
    end
    // check byte: frame is good when it equals the complemented sum
    if (data == ~checksum) begin
      cmd.command_code  = payload[0];
      cmd.output_select = payload[1];
      cmd.timer_value   = {payload[2], payload[3], payload[4], payload[5]};
      expected_commands.push_back(cmd);
    end
    position = cfr_pkg::FirstPos;
    checksum = '0;
    return 1'b1;
  endfunction

  function void check_command(cfr_pkg::result_t got);
    cfr_pkg::result_t want;
    commands_seen++;
    if (expected_commands.size() == 0) begin
      $display("%0t: unexpected command, got %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_commands.pop_front();
    if (got.command_code !== want.command_code) begin
      $display("%0t: command_code expected %h got %h", $time, want.command_code,
               got.command_code);
      mismatches++;
    end
    if (got.output_select !== want.output_select) begin
      $display("%0t: output_select expected %h got %h", $time, want.output_select,
               got.output_select);
      mismatches++;
    end
    if (got.timer_value !== want.timer_value) begin
      $display("%0t: timer_value expected %h got %h", $time, want.timer_value,
               got.timer_value);
      mismatches++;
    end
  endfunction
endclass

module command_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int TargetWords = 450;
  localparam int HoldCycles  = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // [7:0] data_byte, [8] link_up, [15:9] zero
  logic        s_axis_tuser;    // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;    // [7:0] command_code, [15:8] output_select,
                                // [47:16] timer_value

  frame_decode_tracker tracker = new;
  int cycle_count   = 0;
  int words_counted = 0;   // words the receiver actually took
  int burst_left    = 0;

  command_frame_receiver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: compare every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_command(result_t'(m_axis_tdata));
    end
  end

  // Receiver stall pattern: phases of always ready, coin flip, one in four and
  // mostly ready. Two long hold-offs let the block back up into its input.
  initial begin
    int hold_left;
    int next_hold;
    int phase;
    int phase_left;
    hold_left  = 0;
    next_hold  = 0;
    phase      = 0;
    phase_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && next_hold < 2 &&
          tracker.commands_seen >= (next_hold == 0 ? 3 : 20)) begin
        hold_left = HoldCycles;
        next_hold++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase      = $urandom_range(0, 3);
          phase_left = $urandom_range(16, 80);
        end
        phase_left--;
        case (phase)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (cycle_count % 4 == 0);
          default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Offer one word and hold it until taken; bursts end in a random gap.
  task automatic send_word(func_e kind, logic [7:0] data, logic link);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'b0, link, data};
    do @(posedge clk_i); while (!s_axis_tready);
    if (tracker.note_word(kind, data, link)) words_counted++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_poll(logic link);
    send_word(FUNC_POLL, 8'($urandom_range(0, 255)), link);
  endtask

  // leans toward the byte extremes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // seven bytes of one value, then the check byte (spoiled if asked)
  task automatic send_fixed_frame(logic [7:0] fill, bit corrupt);
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < FrameLength - 1; i++) begin
      sum = sum + fill;
      send_word(FUNC_DATA, fill, 1'($urandom_range(0, 1)));
    end
    send_word(FUNC_DATA, corrupt ? sum : ~sum, 1'($urandom_range(0, 1)));
  endtask

  // Random frame; now and then a link-up poll sits inside it (no effect).
  task automatic send_frame(bit corrupt);
    logic [7:0] b;
    logic [7:0] sum;
    int         poll_at;
    sum     = '0;
    poll_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FrameLength - 1) : -1;
    for (int i = 0; i < FrameLength - 1; i++) begin
      if (i == poll_at) send_poll(1'b1);
      b   = pick_byte();
      sum = sum + b;
      send_word(FUNC_DATA, b, 1'($urandom_range(0, 1)));
    end
    if (poll_at == FrameLength - 1) send_poll(1'b1);
    b = ~sum;
    if (corrupt) b = b ^ 8'($urandom_range(1, 255));
    send_word(FUNC_DATA, b, 1'($urandom_range(0, 1)));
  endtask

  // Partial frame cut by a link drop, stray bytes while idle, then relink.
  task automatic send_broken_frame();
    int n;
    n = $urandom_range(1, FrameLength - 1);
    repeat (n) send_word(FUNC_DATA, pick_byte(), 1'($urandom_range(0, 1)));
    send_poll(1'b0);
    repeat ($urandom_range(0, 3)) send_word(FUNC_DATA, pick_byte(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0) send_poll(1'b0);
    send_poll(1'b1);
  endtask

  initial begin
    int r;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = FUNC_DATA;
    s_axis_tdata  = '0;
    // reset falls just after time zero so every flop sees the edge
    #1 rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle byte, polls in both link states, extreme frames, bad
    // checksum, partial frame dropped by a link-down poll
    send_word(FUNC_DATA, 8'hA5, 1'b1);
    send_poll(1'b0);
    send_poll(1'b1);
    send_poll(1'b1);
    send_fixed_frame(8'h00, 1'b1);
    send_fixed_frame(8'hFF, 1'b0);
    send_word(FUNC_DATA, 8'h3C, 1'b0);
    send_word(FUNC_DATA, 8'hC3, 1'b1);
    send_poll(1'b0);
    send_word(FUNC_DATA, 8'h5A, 1'b0);
    send_poll(1'b1);

    // random: mostly good frames, some bad checksums, cut frames and polls
    while (words_counted < TargetWords) begin
      r = $urandom_range(0, 99);
      if (r < 72)      send_frame(1'b0);
      else if (r < 82) send_frame(1'b1);
      else if (r < 94) send_broken_frame();
      else             send_poll(1'b1);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (tracker.expected_commands.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_commands.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
